[rtl/itoa_pkg.sv]
// Package for the integer to ASCII radix converter.
// Holds word types, opcode and character constants, and the digit character map.
// Used by the top level, the divider and the checker; depends on nothing.
`default_nettype none

package itoa_pkg;

  // Width of the operand that is actually converted.
  localparam int unsigned VALUE_BITS = 64;

  // The divider consumes this many dividend bits in each cycle.
  localparam int unsigned DIV_BITS_PER_CYCLE = 8;
  localparam int unsigned DIV_CYCLES = (VALUE_BITS + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
  localparam int unsigned DIV_XW     = DIV_CYCLES * DIV_BITS_PER_CYCLE;
  localparam int unsigned DIV_SUB_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Character buffer: every digit plus up to two prefix characters.
  localparam int unsigned BUF_DEPTH = VALUE_BITS + 2;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned BUF_CW    = $clog2(BUF_DEPTH + 1);

  // Opcodes.
  localparam logic [2:0] OP_SDEC  = 3'd0;
  localparam logic [2:0] OP_UDEC  = 3'd1;
  localparam logic [2:0] OP_OCT   = 3'd2;
  localparam logic [2:0] OP_HEX   = 3'd3;
  localparam logic [2:0] OP_RADIX = 3'd4;

  // Sign modes for signed decimal.
  localparam logic [1:0] SIGN_SPACE = 2'd1;
  localparam logic [1:0] SIGN_PLUS  = 2'd2;

  // Radix limits.
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;

  // ASCII characters.
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUESTION = 8'h3f;
  localparam logic [7:0] CH_X_LOWER  = 8'h78;
  localparam logic [7:0] CH_X_UPPER  = 8'h58;
  localparam logic [7:0] CH_A_LOWER  = 8'h61;
  localparam logic [7:0] CH_A_UPPER  = 8'h41;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
    logic [5:0]  radix;
    logic        upper_case;
    logic        alternate_form;
    logic [1:0]  sign_mode;
  } itoa_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
    logic       bad_radix;
  } itoa_out_t;

  // Commands from the sequencer to the divider.
  typedef struct packed {
    logic              load;
    logic [DIV_XW-1:0] value;
    logic [5:0]        base;
    logic              pow2;
    logic [2:0]        shift;
  } div_cmd_t;

  // Status from the divider.
  typedef struct packed {
    logic       digit_valid;
    logic [5:0] digit;
    logic       last;
  } div_stat_t;

  // Maps a digit value below 36 to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic up);
    logic [7:0] letter_base;
    letter_base = up ? CH_A_UPPER : CH_A_LOWER;
    if (d < 6'd10) begin
      return CH_ZERO + {2'b00, d};
    end
    return letter_base + {2'b00, d} - 8'd10;
  endfunction

endpackage

`default_nettype wire

[rtl/integer_to_ascii_radix_top.sv]
// Top level of the integer to ASCII radix converter.
// Depends on itoa_pkg, itoa_div (shared digit unit) and itoa_ram (character buffer).
`default_nettype none

// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    itoa_in_t: opcode, value, radix, flags
// out      output     out_valid_o / out_ready_i  itoa_out_t: one character, last, error
//
// After a word is accepted, the digits come out least significant first: bases 2, 4, 8,
// 16 and 32 take each digit by a shift, other bases use the shared divider, which
// retires eight quotient bits per cycle. Then come the prefix characters, one buffer
// read, and the characters, emitted one by one as the receiver takes them.
// Reset clears the sequencer and the output valid; the character buffer needs no clearing.
// A stalled output holds its word; the next input word is taken as soon as the previous
// word's last character sits in the output register.

module integer_to_ascii_radix_top
  import itoa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itoa_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output itoa_out_t out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_PFX  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [BUF_CW-1:0] cnt_q, cnt_d;
  logic [1:0]        pfx_len_q, pfx_len_d;
  logic [7:0]        pfx0_q, pfx0_d, pfx1_q, pfx1_d;
  logic              upper_q, upper_d;
  logic              bad_q, bad_d;
  logic              out_valid_q, out_valid_d;
  itoa_out_t         out_q, out_d;

  logic              accept;
  div_cmd_t          div_cmd;
  div_stat_t         div_stat;
  logic              buf_we, buf_re;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]        buf_wdata, buf_rdata;
  logic              can_load;

  // Decoded fields of the incoming word.
  logic [VALUE_BITS-1:0] in_val, in_mag;
  logic                  in_neg;
  logic [5:0]            in_base;
  logic                  in_ok;
  logic                  in_pow2;
  logic [2:0]            in_shift;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign can_load   = !out_valid_q || out_ready_i;

  always_comb begin
    in_val = in_data_i.value[VALUE_BITS-1:0];
    in_neg = (in_data_i.opcode == OP_SDEC) && in_val[VALUE_BITS-1];
    // The most negative value wraps to itself, which is its correct magnitude unsigned.
    in_mag = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;

    case (in_data_i.opcode)
      OP_SDEC, OP_UDEC: begin
        in_base = 6'd10;
        in_ok   = 1'b1;
      end
      OP_OCT: begin
        in_base = 6'd8;
        in_ok   = 1'b1;
      end
      OP_HEX: begin
        in_base = 6'd16;
        in_ok   = 1'b1;
      end
      OP_RADIX: begin
        in_base = in_data_i.radix;
        in_ok   = (in_data_i.radix >= RADIX_MIN) && (in_data_i.radix <= RADIX_MAX);
      end
      default: begin
        in_base = 6'd10;
        in_ok   = 1'b0;
      end
    endcase

    case (in_base)
      6'd2: begin
        in_pow2  = 1'b1;
        in_shift = 3'd1;
      end
      6'd4: begin
        in_pow2  = 1'b1;
        in_shift = 3'd2;
      end
      6'd8: begin
        in_pow2  = 1'b1;
        in_shift = 3'd3;
      end
      6'd16: begin
        in_pow2  = 1'b1;
        in_shift = 3'd4;
      end
      6'd32: begin
        in_pow2  = 1'b1;
        in_shift = 3'd5;
      end
      default: begin
        in_pow2  = 1'b0;
        in_shift = 3'd0;
      end
    endcase
  end

  assign div_cmd.load  = accept && in_ok;
  assign div_cmd.value = DIV_XW'(in_mag);
  assign div_cmd.base  = in_base;
  assign div_cmd.pow2  = in_pow2;
  assign div_cmd.shift = in_shift;

  itoa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .stat_o (div_stat)
  );

  // Digits land in the buffer least significant first, then the prefix characters
  // on top of them, so reading downward from the top gives the text in order.
  itoa_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pfx_len_d   = pfx_len_q;
    pfx0_d      = pfx0_q;
    pfx1_d      = pfx1_q;
    upper_d     = upper_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    buf_we      = 1'b0;
    buf_waddr   = cnt_q[BUF_AW-1:0];
    buf_wdata   = pfx0_q;
    buf_re      = 1'b0;
    buf_raddr   = BUF_AW'(cnt_q - BUF_CW'(1));

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d     = '0;
          upper_d   = in_data_i.upper_case;
          bad_d     = !in_ok;
          pfx_len_d = 2'd0;
          pfx0_d    = CH_ZERO;
          pfx1_d    = CH_ZERO;
          state_d   = ST_DIV;
          if (!in_ok) begin
            pfx_len_d = 2'd1;
            pfx0_d    = CH_QUESTION;
            state_d   = ST_PFX;
          end else begin
            case (in_data_i.opcode)
              OP_SDEC: begin
                if (in_neg) begin
                  pfx_len_d = 2'd1;
                  pfx0_d    = CH_MINUS;
                end else if (in_data_i.sign_mode == SIGN_SPACE) begin
                  pfx_len_d = 2'd1;
                  pfx0_d    = CH_SPACE;
                end else if (in_data_i.sign_mode == SIGN_PLUS) begin
                  pfx_len_d = 2'd1;
                  pfx0_d    = CH_PLUS;
                end
              end
              OP_OCT: begin
                if (in_data_i.alternate_form && (in_val != '0)) begin
                  pfx_len_d = 2'd1;
                end
              end
              OP_HEX: begin
                if (in_data_i.alternate_form) begin
                  pfx_len_d = 2'd2;
                  pfx0_d    = in_data_i.upper_case ? CH_X_UPPER : CH_X_LOWER;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_DIV: begin
        if (div_stat.digit_valid) begin
          buf_we    = 1'b1;
          buf_wdata = digit_char(div_stat.digit, upper_q);
          cnt_d     = cnt_q + BUF_CW'(1);
          if (div_stat.last) begin
            state_d = ST_PFX;
          end
        end
      end

      ST_PFX: begin
        if (pfx_len_q != 2'd0) begin
          buf_we    = 1'b1;
          cnt_d     = cnt_q + BUF_CW'(1);
          pfx0_d    = pfx1_q;
          pfx_len_d = pfx_len_q - 2'd1;
        end else begin
          // Fetch the topmost character; it is ready in the next cycle.
          buf_re  = 1'b1;
          cnt_d   = cnt_q - BUF_CW'(1);
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (can_load) begin
          out_valid_d     = 1'b1;
          out_d.char_out  = buf_rdata;
          out_d.last_char = (cnt_q == '0);
          out_d.bad_radix = bad_q;
          if (cnt_q != '0) begin
            buf_re = 1'b1;
            cnt_d  = cnt_q - BUF_CW'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    pfx_len_q <= pfx_len_d;
    pfx0_q    <= pfx0_d;
    pfx1_q    <= pfx1_d;
    upper_q   <= upper_d;
    bad_q     <= bad_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/itoa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
`default_nettype none

module itoa_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/itoa_div.sv]
// Shared digit unit: repeatedly divides the operand by the base and reports digits.
// Depends on itoa_pkg for the command and status types and the divider sizing.
`default_nettype none

module itoa_div
  import itoa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  div_cmd_t  cmd_i,
  output div_stat_t stat_o
);

  logic                 run_q;
  logic [DIV_SUB_W-1:0] sub_q, sub_d;
  logic [DIV_XW-1:0]    x_q, x_d;
  logic [5:0]           rem_q, rem_d;
  logic [5:0]           base_q;
  logic                 pow2_q;
  logic [2:0]           shift_q;

  logic       last_sub;
  logic [6:0] r;
  logic [DIV_XW-1:0] xs;
  logic [5:0] digit;

  // Restoring division, several quotient bits per cycle; the remainder never
  // reaches the base, so the partial remainder fits in seven bits.
  always_comb begin
    r  = {1'b0, rem_q};
    xs = x_q;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      r  = {r[5:0], xs[DIV_XW-1]};
      xs = {xs[DIV_XW-2:0], 1'b0};
      if (r >= {1'b0, base_q}) begin
        r     = r - {1'b0, base_q};
        xs[0] = 1'b1;
      end
    end
  end

  always_comb begin
    last_sub = pow2_q || (sub_q == DIV_SUB_W'(DIV_CYCLES - 1));
    if (pow2_q) begin
      x_d   = x_q >> shift_q;
      digit = x_q[5:0] & (base_q - 6'd1);
    end else begin
      x_d   = xs;
      digit = r[5:0];
    end
    rem_d = last_sub ? 6'd0 : r[5:0];
    sub_d = last_sub ? '0 : sub_q + DIV_SUB_W'(1);
  end

  assign stat_o.digit_valid = run_q && last_sub;
  assign stat_o.digit       = digit;
  assign stat_o.last        = (x_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      sub_q <= '0;
    end else if (cmd_i.load) begin
      run_q <= 1'b1;
      sub_q <= '0;
    end else if (run_q) begin
      sub_q <= sub_d;
      if (last_sub && x_d == '0) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= cmd_i.value;
      rem_q   <= 6'd0;
      base_q  <= cmd_i.base;
      pow2_q  <= cmd_i.pow2;
      shift_q <= cmd_i.shift;
    end else if (run_q) begin
      x_q   <= x_d;
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

[rtl/itoa_chk.sv]
// Port-level checker for the integer to ASCII radix converter, bound to the top level.
// Depends on itoa_pkg for the word types and character constants.
`default_nettype none

module itoa_chk
  import itoa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input itoa_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input itoa_out_t out_data_o
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // The block is not ready in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // The error word is a single question mark.
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_radix |->
      out_data_o.last_char && (out_data_o.char_out == CH_QUESTION))
    else $error("error word is not a lone question mark");

  // No output word is offered while a new input can be taken unless it ends a conversion.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_ready_o && !$past(in_ready_o) |-> out_data_o.last_char)
    else $error("block went idle before the last character");

endmodule

bind integer_to_ascii_radix_top itoa_chk u_itoa_chk (.*);

`default_nettype wire

[tb/integer_to_ascii_radix_top_tb.sv]
// Self-checking testbench for integer_to_ascii_radix_top, the integer to ASCII converter.
// Drives conversion words, predicts each character and checks it on the output channel.
// Depends on itoa_pkg for the word types, opcodes and character constants.
`default_nettype none

module integer_to_ascii_radix_top_tb
  import itoa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Random words after the directed rows, and the points in that stream where the
  // receiver takes its long hold-off, the sender drains the block, and idling stops.
  localparam int RANDOM_WORDS  = 480;
  localparam int HOLD_AT       = 120;
  localparam int DRAIN_AT      = 300;
  localparam int CALM_FROM     = 420;
  localparam int HOLD_CYCLES   = 400;
  // Wait after the last owed character before the run ends.
  localparam int TAIL_CYCLES   = 400;
  // Worst word: 41 base-3 digits, or 64 characters each stalled by the receiver,
  // after an input gap. Several times that over every word.
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int MAX_REPORTS   = 40;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  itoa_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  itoa_out_t out_data_o;

  // Characters still owed by the block, oldest first.
  itoa_out_t pending_chars[$];

  // Receiver controls, written with nonblocking assignments so that the
  // receiver process never sees them change mid-step.
  bit hold_request = 1'b0;
  bit calm = 1'b0;

  int mismatches = 0;
  int words_sent = 0;
  int chars_checked = 0;
  int error_marks = 0;
  int cycle_count = 0;

  string lower_digits = "0123456789abcdefghijklmnopqrstuvwxyz";
  string upper_digits = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct {
    itoa_in_t word;
    string    text;   // empty means the predictor supplies the characters
    bit       bad;
  } directed_row_t;

  directed_row_t directed_rows[$];

  integer_to_ascii_radix_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Appends the characters of a conversion to the queue of owed characters.
  function automatic void owe_text(input logic [7:0] chars[$], input bit bad);
    itoa_out_t c;
    for (int i = 0; i < chars.size(); i++) begin
      c.char_out  = chars[i];
      c.last_char = (i == chars.size() - 1);
      c.bad_radix = bad;
      pending_chars.push_back(c);
    end
  endfunction

  // Works out the text the block must produce for one word: sign or radix
  // prefix, then the digits most significant first, or a lone '?' when the
  // opcode or the radix is out of range.
  function automatic void format_chars(input itoa_in_t w);
    logic [63:0] mask;
    logic [63:0] mag;
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    int unsigned base;
    bit          up;
    bit          bad;
    string       digit_set;
    mask = {64{1'b1}} >> (64 - VALUE_BITS);
    mag  = w.value & mask;
    base = 10;
    up   = 1'b0;
    bad  = 1'b0;
    case (w.opcode)
      OP_SDEC: begin
        // Negatives always get a minus, whatever the sign mode says; the most
        // negative value negates onto itself and reads correctly as unsigned.
        if (mag[VALUE_BITS-1]) begin
          text.push_back(CH_MINUS);
          mag = (~mag + 64'd1) & mask;
        end else if (w.sign_mode == SIGN_SPACE) begin
          text.push_back(CH_SPACE);
        end else if (w.sign_mode == SIGN_PLUS) begin
          text.push_back(CH_PLUS);
        end
      end
      OP_UDEC: begin
      end
      OP_OCT: begin
        base = 8;
        if (w.alternate_form && mag != 0) begin
          text.push_back(CH_ZERO);
        end
      end
      OP_HEX: begin
        base = 16;
        up = w.upper_case;
        // The hex prefix is kept even for zero.
        if (w.alternate_form) begin
          text.push_back(CH_ZERO);
          text.push_back(up ? CH_X_UPPER : CH_X_LOWER);
        end
      end
      OP_RADIX: begin
        up = w.upper_case;
        if (w.radix >= RADIX_MIN && w.radix <= RADIX_MAX) begin
          base = {26'd0, w.radix};
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      text.delete();
      text.push_back(CH_QUESTION);
    end else begin
      digit_set = up ? upper_digits : lower_digits;
      do begin
        digits.push_front(digit_set[int'(mag % base)]);
        mag = mag / base;
      end while (mag != 0);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    owe_text(text, bad);
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [63:0] value,
                                  input logic [5:0] radix, input bit up, input bit alt,
                                  input logic [1:0] sm, input string text, input bit bad);
    directed_row_t r;
    r.word.opcode         = op;
    r.word.value          = value;
    r.word.radix          = radix;
    r.word.upper_case     = up;
    r.word.alternate_form = alt;
    r.word.sign_mode      = sm;
    r.text = text;
    r.bad  = bad;
    directed_rows.push_back(r);
  endfunction

  // A random conversion word. Values lean toward short numbers and the sign
  // and width boundaries, with full-width values mixed in.
  function automatic itoa_in_t random_word();
    itoa_in_t w;
    w.opcode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
    case ($urandom_range(0, 5))
      0: w.value = {$urandom, $urandom};
      1: w.value = 64'($urandom_range(0, 1000));
      2: w.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: w.value = 64'd0 - 64'($urandom_range(1, 1000));
      4: begin
        case ($urandom_range(0, 5))
          0: w.value = 64'd0;
          1: w.value = {64{1'b1}};
          2: w.value = 64'h8000_0000_0000_0000;
          3: w.value = 64'h7fff_ffff_ffff_ffff;
          4: w.value = 64'd1 << $urandom_range(0, 63);
          default: w.value = (64'd1 << $urandom_range(1, 63)) - 64'd1;
        endcase
      end
      default: w.value = {1'b1, 63'({$urandom, $urandom})};
    endcase
    w.radix = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(2, 36));
    w.upper_case     = 1'($urandom);
    w.alternate_form = 1'($urandom);
    w.sign_mode      = 2'($urandom_range(0, 3));
    return w;
  endfunction

  // Offers one word on the input channel, with an occasional idle burst in
  // front of it, and records what it owes once the handshake completes.
  task automatic offer_word(input itoa_in_t w, input string text, input bit bad);
    logic [7:0] chars[$];
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (text.len() == 0) begin
      format_chars(w);
    end else begin
      for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
      owe_text(chars, bad);
    end
  endtask

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, and a steady
  // ready once the calm tail of the run begins.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request <= 1'b0;
      end else if (burst > 0) begin
        out_ready_i <= 1'b0;
        burst--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        burst = $urandom_range(1, 16) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Output checker: every accepted character is compared with the oldest one
  // still owed. Signals read right after the edge still hold their pre-edge values.
  initial begin
    itoa_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        chars_checked++;
        if (out_data_o.bad_radix) error_marks++;
        if (pending_chars.size() == 0) begin
          note_mismatch("unrequested char_out", 0, out_data_o.char_out);
        end else begin
          want = pending_chars.pop_front();
          if (out_data_o.char_out !== want.char_out)
            note_mismatch("char_out", want.char_out, out_data_o.char_out);
          if (out_data_o.last_char !== want.last_char)
            note_mismatch("last_char", want.last_char, out_data_o.last_char);
          if (out_data_o.bad_radix !== want.bad_radix)
            note_mismatch("bad_radix", want.bad_radix, out_data_o.bad_radix);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run did not finish within %0d cycles", $realtime, LIMIT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    itoa_in_t w;

    // Directed rows. Text is typed in where it is plain to read; the rest go
    // through the predictor.
    add_row(OP_SDEC, 64'd0, 6'd0, 1'b0, 1'b0, 2'd0, "0", 1'b0);
    add_row(OP_SDEC, 64'd0, 6'd0, 1'b0, 1'b0, SIGN_SPACE, " 0", 1'b0);
    add_row(OP_SDEC, 64'd5, 6'd0, 1'b0, 1'b0, SIGN_PLUS, "+5", 1'b0);
    add_row(OP_SDEC, {64{1'b1}}, 6'd0, 1'b0, 1'b0, SIGN_PLUS, "-1", 1'b0);
    add_row(OP_SDEC, 64'h8000_0000_0000_0000, 6'd0, 1'b0, 1'b0, SIGN_SPACE,
            "-9223372036854775808", 1'b0);
    add_row(OP_SDEC, 64'h7fff_ffff_ffff_ffff, 6'd0, 1'b0, 1'b1, 2'd0,
            "9223372036854775807", 1'b0);
    // Sign mode three behaves like minus-only.
    add_row(OP_SDEC, 64'd0 - 64'd5, 6'd0, 1'b1, 1'b1, 2'd3, "-5", 1'b0);
    add_row(OP_SDEC, 64'd7, 6'd0, 1'b0, 1'b0, 2'd3, "7", 1'b0);
    add_row(OP_UDEC, {64{1'b1}}, 6'd63, 1'b1, 1'b1, SIGN_PLUS,
            "18446744073709551615", 1'b0);
    add_row(OP_UDEC, 64'd0, 6'd0, 1'b0, 1'b0, 2'd0, "0", 1'b0);
    // Octal zero gets no leading zero, hex zero keeps its prefix.
    add_row(OP_OCT, 64'd0, 6'd0, 1'b0, 1'b1, 2'd0, "0", 1'b0);
    add_row(OP_OCT, 64'd8, 6'd0, 1'b1, 1'b1, 2'd0, "010", 1'b0);
    add_row(OP_OCT, {64{1'b1}}, 6'd0, 1'b0, 1'b0, SIGN_SPACE,
            "1777777777777777777777", 1'b0);
    add_row(OP_HEX, 64'd0, 6'd0, 1'b0, 1'b1, 2'd0, "0x0", 1'b0);
    add_row(OP_HEX, 64'd0, 6'd0, 1'b1, 1'b1, 2'd0, "0X0", 1'b0);
    add_row(OP_HEX, 64'hdead_beef, 6'd0, 1'b1, 1'b0, 2'd0, "DEADBEEF", 1'b0);
    add_row(OP_HEX, {64{1'b1}}, 6'd0, 1'b0, 1'b1, 2'd0, "0xffffffffffffffff", 1'b0);
    add_row(OP_RADIX, {64{1'b1}}, RADIX_MIN, 1'b0, 1'b0, 2'd0, "", 1'b0);
    add_row(OP_RADIX, 64'd35, RADIX_MAX, 1'b1, 1'b0, 2'd0, "Z", 1'b0);
    add_row(OP_RADIX, {64{1'b1}}, RADIX_MAX, 1'b0, 1'b1, SIGN_PLUS, "", 1'b0);
    add_row(OP_RADIX, 64'h0123_4567_89ab_cdef, 6'd3, 1'b1, 1'b0, 2'd0, "", 1'b0);
    // Radix values either side of the legal range, and undefined opcodes.
    add_row(OP_RADIX, 64'd12, 6'd0, 1'b0, 1'b0, 2'd0, "?", 1'b1);
    add_row(OP_RADIX, 64'd12, 6'd1, 1'b0, 1'b0, 2'd0, "?", 1'b1);
    add_row(OP_RADIX, 64'd12, 6'd37, 1'b0, 1'b0, 2'd0, "?", 1'b1);
    add_row(OP_RADIX, 64'd12, 6'd63, 1'b1, 1'b1, 2'd3, "?", 1'b1);
    add_row(3'd5, 64'd1, 6'd10, 1'b0, 1'b0, 2'd0, "?", 1'b1);
    add_row(3'd7, {64{1'b1}}, 6'd10, 1'b1, 1'b1, 2'd3, "?", 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].word, directed_rows[i].text, directed_rows[i].bad);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Long receiver hold-off while the sender keeps offering, so the block
      // backs up and drops in_ready_o.
      if (n == HOLD_AT) hold_request <= 1'b1;
      // Sender pause until the block has emitted everything it owes.
      if (n == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk_i);
      end
      if (n == CALM_FROM) calm <= 1'b1;
      w = random_word();
      offer_word(w, "", 1'b0);
    end
    in_valid_i <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d words (%0d directed) across every opcode and bad radix value,",
             words_sent, directed_rows.size());
    $display("checking %0d characters, %0d of them error markers, in %0d cycles.",
             chars_checked, error_marks, cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
